### hw/rtl/stc_pkg.sv
// Shared types, widths and codes for the scope trigger capture block.
`default_nettype none

package stc_pkg;

    localparam int RING_DEPTH_DEF = 512;

    localparam int SMP_W      = 12;
    localparam int CMD_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int PRE_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [SMP_W-1:0] LEVEL_RST = 12'd2048;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE  = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_SW_TRIG = 3'd3,
        CMD_READ    = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL = 2'd0,
        REG_MODE  = 2'd1,
        REG_EDGE  = 2'd2,
        REG_PRE   = 2'd3
    } cfg_reg_t;

    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_WAIT     = 4'b0010,
        ST_SAMPLING = 4'b0100,
        ST_DONE     = 4'b1000
    } state_t;

    localparam logic [STATUS_W-1:0] STAT_IDLE     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_WAIT     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SAMPLING = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd3;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ring_ctl_t;

    function automatic logic [STATUS_W-1:0] status_of(input state_t st);
        logic [STATUS_W-1:0] code;
        begin
            unique case (st)
                ST_IDLE:     code = STAT_IDLE;
                ST_WAIT:     code = STAT_WAIT;
                ST_SAMPLING: code = STAT_SAMPLING;
                ST_DONE:     code = STAT_DONE;
                default:     code = STAT_IDLE;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/scope_trigger_capture.sv
// Scope edge trigger with pre-trigger ring capture and byte readout.
// Each item passes through the input register and then the result register, which part the sides.
// Throughput: one item per cycle unless out_stall holds the result register.
// Each item is decoded in one pass; the ring memory takes at most one write or one read per item.
// Reset (rst_n, async, active low) clears control state and status registers, not cmd_reg or smp_reg.
// Ring entry zero reads as zero until written; no clearing pass is needed after reset.
`default_nettype none

module scope_trigger_capture
    import stc_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CMD_W-1:0]      cmd,
    input  wire logic [SMP_W-1:0]      sample,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [BYTE_W-1:0]     read_byte,
    output logic                       byte_valid,
    output logic                       last_byte,
    output logic      [STATUS_W-1:0]   scope_status
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int REM_W = $clog2(RING_DEPTH + 1);
    localparam int RCP_K = PRE_W + PTR_W;
    localparam int MUL_W = PRE_W + RCP_K;
    localparam int CW    = ((PTR_W > PRE_W) ? PTR_W : PRE_W) + 1;
    localparam int QD_W  = CW + PRE_W;
    localparam logic [RCP_K-1:0] RCP_M   = RCP_K'((64'd1 << RCP_K) / RING_DEPTH);
    localparam logic [CW-1:0]    DEPTH_C = CW'(RING_DEPTH);
    localparam logic [REM_W-1:0] DEPTH_R = REM_W'(RING_DEPTH);
    localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(RING_DEPTH);

    // configuration
    logic [SMP_W-1:0]  level_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              edge_reg;
    logic [PRE_W-1:0]  pre_raw_reg;
    logic [PRE_W-1:0]  pre_q_reg;
    logic [MUL_W-1:0]  pre_prod;
    logic [QD_W-1:0]   pre_qd;
    logic [CW-1:0]     pre_r0;
    logic [CW-1:0]     pre_r1;
    logic [PTR_W-1:0]  pre_eff;

    // pipeline
    logic              s1_valid_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [SMP_W-1:0]  smp_reg;
    logic              adv;
    logic              proc_en;
    logic              out_valid_reg;
    logic              byte_valid_reg;
    logic              last_reg;
    logic [STATUS_W-1:0] status_reg;

    // capture state
    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  sp_reg, sp_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              wrapped_reg, wrapped_next;
    logic              armed_reg, armed_next;

    logic [PTR_W:0]    winc;
    logic [PTR_W:0]    rinc;
    logic              passed;
    logic              beyond;
    logic              approach;
    logic              fire;
    logic              bv_next;
    logic              last_next;

    ring_ctl_t         ring_ctl;
    logic [PTR_W-1:0]  wr_addr;
    logic [PTR_W-1:0]  rd_addr;
    logic [SMP_W-1:0]  rd_data;

    function automatic logic [PTR_W:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] s;
        begin
            s = {1'b0, p} + (PTR_W + 1)'(1);
            if (s >= DEPTH_P)
            begin
                return {1'b1, PTR_W'(0)};
            end
            return {1'b0, s[PTR_W-1:0]};
        end
    endfunction

    function automatic logic [REM_W-1:0] trig_rem(
        input logic [PTR_W-1:0] wp,
        input logic             wr,
        input logic [PTR_W-1:0] pre
    );
        begin
            if (wr || (wp > pre))
            begin
                return DEPTH_R - REM_W'(pre);
            end
            return DEPTH_R - REM_W'(wp) - REM_W'(1);
        end
    endfunction

    // pre-trigger count modulo ring depth: reciprocal quotient taken at the write
    assign pre_prod = MUL_W'(cfg_wdata[PRE_W-1:0]) * MUL_W'(RCP_M);
    assign pre_qd   = QD_W'(pre_q_reg) * QD_W'(RING_DEPTH);
    assign pre_r0   = CW'(pre_raw_reg) - pre_qd[CW-1:0];
    assign pre_r1   = (pre_r0 >= DEPTH_C) ? (pre_r0 - DEPTH_C) : pre_r0;
    assign pre_eff  = pre_r1[PTR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= LEVEL_RST;
            mode_reg    <= MODE_SINGLE;
            edge_reg    <= 1'b0;
            pre_raw_reg <= '0;
            pre_q_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LEVEL: level_reg <= cfg_wdata[SMP_W-1:0];
                REG_MODE:  mode_reg  <= cfg_wdata[MODE_W-1:0];
                REG_EDGE:  edge_reg  <= cfg_wdata[0];
                REG_PRE:
                begin
                    pre_raw_reg <= cfg_wdata[PRE_W-1:0];
                    pre_q_reg   <= pre_prod[MUL_W-1:RCP_K];
                end
                default:   ;
            endcase
        end
    end

    assign adv      = !out_valid_reg || !out_stall;
    assign proc_en  = s1_valid_reg && adv;
    assign in_stall = s1_valid_reg && !adv;

    always_comb
    begin
        winc         = ptr_inc(wp_reg);
        rinc         = ptr_inc(rp_reg);
        passed       = (wp_reg > pre_eff) || wrapped_reg;
        beyond       = edge_reg ? (smp_reg < level_reg) : (smp_reg > level_reg);
        approach     = edge_reg ? (smp_reg > level_reg) : (smp_reg < level_reg);
        fire         = 1'b0;
        state_next   = state_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        sp_next      = sp_reg;
        rem_next     = rem_reg;
        wrapped_next = wrapped_reg;
        armed_next   = armed_reg;
        ring_ctl     = '0;
        wr_addr      = winc[PTR_W-1:0];
        rd_addr      = rp_reg;
        bv_next      = 1'b0;
        last_next    = 1'b0;
        if (proc_en)
        begin
            unique case (cmd_t'(cmd_reg))
                CMD_SAMPLE:
                begin
                    if (state_reg == ST_WAIT)
                    begin
                        if (passed && (mode_reg != MODE_AUTO))
                        begin
                            if (beyond && armed_reg)
                            begin
                                fire       = 1'b1;
                                armed_next = 1'b0;
                            end
                            if (approach)
                            begin
                                armed_next = 1'b1;
                            end
                        end
                        ring_ctl.wr_en = 1'b1;
                        wp_next        = winc[PTR_W-1:0];
                        wrapped_next   = wrapped_reg | winc[PTR_W];
                        if (fire || (mode_reg == MODE_AUTO))
                        begin
                            armed_next = 1'b0;
                            state_next = ST_SAMPLING;
                            rem_next   = trig_rem(winc[PTR_W-1:0],
                                                  wrapped_reg | winc[PTR_W], pre_eff);
                        end
                    end
                    else if (state_reg == ST_SAMPLING)
                    begin
                        if (rem_reg == '0)
                        begin
                            sp_next    = winc[PTR_W-1:0];
                            rp_next    = winc[PTR_W-1:0];
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ring_ctl.wr_en = 1'b1;
                            wp_next        = winc[PTR_W-1:0];
                            wrapped_next   = wrapped_reg | winc[PTR_W];
                            rem_next       = rem_reg - REM_W'(1);
                        end
                    end
                end
                CMD_START:
                begin
                    state_next   = ST_WAIT;
                    wp_next      = '0;
                    rp_next      = '0;
                    sp_next      = '0;
                    rem_next     = '0;
                    wrapped_next = 1'b0;
                end
                CMD_STOP:
                begin
                    state_next = ST_IDLE;
                end
                CMD_SW_TRIG:
                begin
                    if (state_reg == ST_WAIT)
                    begin
                        state_next = ST_SAMPLING;
                        rem_next   = trig_rem(wp_reg, wrapped_reg, pre_eff);
                    end
                end
                CMD_READ:
                begin
                    if (state_reg == ST_DONE)
                    begin
                        ring_ctl.rd_en = 1'b1;
                        bv_next        = 1'b1;
                        rp_next        = rinc[PTR_W-1:0];
                        if (rinc[PTR_W-1:0] == sp_reg)
                        begin
                            last_next = 1'b1;
                            if (mode_reg == MODE_SINGLE)
                            begin
                                state_next = ST_IDLE;
                            end
                            else if (mode_reg inside {MODE_NORMAL, MODE_AUTO})
                            begin
                                state_next   = ST_WAIT;
                                wp_next      = '0;
                                rp_next      = '0;
                                sp_next      = '0;
                                rem_next     = '0;
                                wrapped_next = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg <= cmd;
            smp_reg <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            byte_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
            status_reg     <= STAT_IDLE;
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            sp_reg         <= '0;
            rem_reg        <= '0;
            wrapped_reg    <= 1'b0;
            armed_reg      <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (proc_en)
            begin
                byte_valid_reg <= bv_next;
                last_reg       <= last_next;
                status_reg     <= status_of(state_next);
            end
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            sp_reg      <= sp_next;
            rem_reg     <= rem_next;
            wrapped_reg <= wrapped_next;
            armed_reg   <= armed_next;
        end
    end

    stc_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ring_ctl),
        .wr_addr (wr_addr),
        .wr_data (smp_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid    = out_valid_reg;
    assign byte_valid   = byte_valid_reg;
    assign last_byte    = last_reg;
    assign scope_status = status_reg;
    assign read_byte    = byte_valid_reg ? rd_data[SMP_W-1:SMP_W-BYTE_W] : '0;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid || !last_byte))
        else $error("last byte flagged without a valid byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (proc_en && (cmd_reg == CMD_READ) && (state_reg == ST_DONE))
        |=> (out_valid && byte_valid))
        else $error("read in done state produced no byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAMPLING) |-> (rem_reg <= DEPTH_R))
        else $error("remaining count beyond ring depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg <= PTR_W'(RING_DEPTH - 1)) && (rp_reg <= PTR_W'(RING_DEPTH - 1)))
        else $error("ring pointer out of range");
`endif

endmodule

`default_nettype wire

### hw/rtl/stc_ring.sv
// Capture ring memory with registered read data and reset view of entry zero.
`default_nettype none

module stc_ring
    import stc_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ring_ctl_t                     ctl,
    input  wire logic [$clog2(RING_DEPTH)-1:0] wr_addr,
    input  wire logic [SMP_W-1:0]              wr_data,
    input  wire logic [$clog2(RING_DEPTH)-1:0] rd_addr,
    output logic      [SMP_W-1:0]              rd_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);

    logic [SMP_W-1:0] mem [RING_DEPTH];
    logic [SMP_W-1:0] rdata_reg;
    logic             written0_reg;
    logic             blank_reg;

    // Every capture writes all entries but possibly entry zero, so only it needs a flag.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written0_reg <= 1'b0;
            blank_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en && (wr_addr == PTR_W'(0)))
            begin
                written0_reg <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                blank_reg <= (rd_addr == PTR_W'(0)) && !written0_reg;
            end
        end
    end

    assign rd_data = blank_reg ? '0 : rdata_reg;

endmodule

`default_nettype wire
